FILE: hw/rtl/wfe_pkg.sv
// ----------------------------------------------------------------------------
// wfe_pkg
// Shared types and constants for the Wiegand frame encoder.
// ----------------------------------------------------------------------------
package wfe_pkg;

  // Byte counts that select the 26/34/66-bit (or 24/32/64-bit) formats.
  localparam logic [3:0] COUNT_SHORT = 4'd3;
  localparam logic [3:0] COUNT_MID   = 4'd4;
  localparam logic [3:0] COUNT_LONG  = 4'd8;

  // Chunk lengths.
  localparam logic [3:0] LEN_NONE   = 4'd0;
  localparam logic [3:0] LEN_PARITY = 4'd1;
  localparam logic [3:0] LEN_BYTE   = 4'd8;

  // Status codes.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_COUNT = 1'b1;

  // Highest chunk index of a frame: leading parity, eight bytes, trailing parity.
  localparam logic [3:0] STEP_MAX = 4'd9;

  typedef struct packed {
    logic [7:0] bits;
    logic [3:0] length;
    logic       status;
    logic       last;
  } chunk_t;

endpackage

FILE: hw/rtl/wfe_frame_seq.sv
// ----------------------------------------------------------------------------
// wfe_frame_seq
// Frame register and chunk sequencer: holds one frame with its parity bits
// and presents its chunks one at a time.
// ----------------------------------------------------------------------------
module wfe_frame_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic [63:0]     frame_data,
  input  logic [3:0]      byte_count,
  input  logic            parity_on,
  input  logic            advance,
  output logic            busy,
  output wfe_pkg::chunk_t chunk
);
  import wfe_pkg::*;

  logic        active;
  logic [63:0] data;
  logic [3:0]  count;
  logic        par;
  logic        even_p;
  logic        odd_p;
  logic        err;
  logic [3:0]  step;

  logic        in_err;
  logic        in_even;
  logic        in_odd;
  logic        is_byte;

  // Parity over the first and second half of the data bits of each format.
  always_comb begin
    in_err  = 1'b0;
    in_even = 1'b0;
    in_odd  = 1'b1;
    unique case (byte_count)
      COUNT_SHORT: begin
        in_even = ^frame_data[63:52];
        in_odd  = ~(^frame_data[51:40]);
      end
      COUNT_MID: begin
        in_even = ^frame_data[63:48];
        in_odd  = ~(^frame_data[47:32]);
      end
      COUNT_LONG: begin
        in_even = ^frame_data[63:32];
        in_odd  = ~(^frame_data[31:0]);
      end
      default: begin
        in_err = 1'b1;
      end
    endcase
  end

  always_comb begin
    is_byte = 1'b0;
    if (err) begin
      chunk = '{bits: 8'd0, length: LEN_NONE, status: STATUS_BAD_COUNT, last: 1'b1};
    end else if (par && step == 4'd0) begin
      chunk = '{bits: {7'd0, even_p}, length: LEN_PARITY, status: STATUS_OK, last: 1'b0};
    end else if (par && step == count + 4'd1) begin
      chunk = '{bits: {7'd0, odd_p}, length: LEN_PARITY, status: STATUS_OK, last: 1'b1};
    end else begin
      is_byte = 1'b1;
      chunk = '{bits: data[63:56], length: LEN_BYTE, status: STATUS_OK,
                last: !par && step == count - 4'd1};
    end
  end

  assign busy = active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= 4'd0;
    end else begin
      if (advance && active) begin
        if (chunk.last) begin
          active <= 1'b0;
        end else begin
          step <= step + 4'd1;
        end
        if (is_byte) begin
          data <= {data[55:0], 8'd0};
        end
      end
      if (load) begin
        active <= 1'b1;
        step   <= 4'd0;
        data   <= frame_data;
        count  <= byte_count;
        par    <= parity_on;
        even_p <= in_even;
        odd_p  <= in_odd;
        err    <= in_err;
      end
    end
  end

  // A frame never runs past its trailing parity chunk.
  assert property (@(posedge clk) disable iff (rst) active |-> step <= STEP_MAX)
    else $error("chunk index ran past the end of the frame");

  // A loaded frame is always presented on the next cycle.
  assert property (@(posedge clk) disable iff (rst) load |=> active && step == 4'd0)
    else $error("loaded frame not presented from its first chunk");

  // The sequence only moves when a chunk is taken.
  assert property (@(posedge clk) disable iff (rst)
    active && !advance && !load |=> active && $stable(step))
    else $error("chunk sequence moved without a taken chunk");

endmodule

FILE: hw/rtl/wiegand_frame_encoder.sv
// ----------------------------------------------------------------------------
// wiegand_frame_encoder
// Turns one ID frame into the chunk sequence of a Wiegand transmission.
// ----------------------------------------------------------------------------
// Each accepted word is a whole frame and produces one chunk per unstalled
// cycle on the output side: byte_count + 2 chunks with parity on, byte_count
// chunks with parity off, and a single error chunk for a count other than 3,
// 4 or 8. A frame therefore occupies the frame register for 1 to 10 chunks,
// and the next frame is accepted in the same cycle that the last chunk of the
// current one moves into the output register, so frames follow with no gap.
// The output register is the only buffer between the two sides; the rate is
// set by the one-chunk-per-cycle sequencer, less any cycles of chunk_stall.
module wiegand_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_valid,
  output logic        frame_stall,
  input  logic [63:0] frame_data,
  input  logic [3:0]  byte_count,
  input  logic        parity_on,
  output logic        chunk_valid,
  input  logic        chunk_stall,
  output logic [7:0]  chunk_bits,
  output logic [3:0]  chunk_length,
  output logic        status,
  output logic        last
);
  import wfe_pkg::*;

  logic   seq_busy;
  chunk_t seq_chunk;
  logic   advance;
  logic   load;

  // A chunk moves forward whenever the output register is empty or draining.
  assign advance     = seq_busy && (!chunk_valid || !chunk_stall);
  assign frame_stall = seq_busy && !(advance && seq_chunk.last);
  assign load        = frame_valid && !frame_stall;

  wfe_frame_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .frame_data (frame_data),
    .byte_count (byte_count),
    .parity_on  (parity_on),
    .advance    (advance),
    .busy       (seq_busy),
    .chunk      (seq_chunk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_valid <= 1'b0;
    end else begin
      if (advance) begin
        chunk_valid  <= 1'b1;
        chunk_bits   <= seq_chunk.bits;
        chunk_length <= seq_chunk.length;
        status       <= seq_chunk.status;
        last         <= seq_chunk.last;
      end else if (!chunk_stall) begin
        chunk_valid <= 1'b0;
      end
    end
  end

endmodule
